// ===== hw/rtl/sce_pkg.sv =====
package sce_pkg;

	localparam int ID_W      = 32;
	localparam int FL_W      = 8;
	localparam int ST_W      = 4;
	localparam int TM_W      = 32;
	localparam int EXP_W     = 33;
	localparam int ORD_W     = 16;
	localparam int TTL_W     = 32;
	localparam int MAXE_W    = 5;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CNT_OUT_W = 5;

	// status codes with a meaning to the cache itself
	localparam logic [ST_W-1:0] ST_NONE    = 4'd0;
	localparam logic [ST_W-1:0] ST_WAIT    = 4'd1;
	localparam logic [ST_W-1:0] ST_CONNECT = 4'd6;
	localparam logic [ST_W-1:0] ST_ISSUER  = 4'd7;
	localparam logic [ST_W-1:0] ST_ERROR   = 4'd10;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_TTL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_TTL    = 2'd2;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_STORE  = 1'b1;

	localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = 5'd16;
	localparam logic [TTL_W-1:0]  NORMAL_TTL_RST  = 32'd3600;
	localparam logic [TTL_W-1:0]  WAIT_TTL_RST    = 32'd60;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [FL_W-1:0]  flags;
		logic [ST_W-1:0]  status;
		logic [EXP_W-1:0] expiry;
		logic [ORD_W-1:0] order;
	} entry_t;

	typedef struct packed {
		logic load;
		logic clr;
		logic purge;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/sce_cell.sv =====
module sce_cell import sce_pkg::*; #(
	parameter int IW   = 5,
	parameter int CW   = 5,
	parameter int SLOT = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  entry_t           wdata,
	input  logic [ID_W-1:0]  key_id,
	input  logic [FL_W-1:0]  key_flags,
	input  logic [TM_W-1:0]  now,
	input  logic [ORD_W-1:0] ins_cnt,
	input  logic             found_in,
	input  logic [EXP_W-1:0] exp_in,
	input  logic [ORD_W-1:0] age_in,
	input  logic [IW-1:0]    idx_in,
	input  logic [CW-1:0]    cnt_in,
	output logic             match,
	output logic             valid,
	output entry_t           ent,
	output logic             found_out,
	output logic [EXP_W-1:0] exp_out,
	output logic [ORD_W-1:0] age_out,
	output logic [IW-1:0]    idx_out,
	output logic [CW-1:0]    cnt_out
);

	logic             valid_q;
	entry_t           ent_q;
	logic             expired;
	logic [ORD_W-1:0] age;
	logic             better;
	logic             found_q;
	logic [EXP_W-1:0] exp_q;
	logic [ORD_W-1:0] age_q;
	logic [IW-1:0]    idx_q;
	logic [CW-1:0]    cnt_q;

	assign expired = ent_q.expiry <= {1'b0, now};
	assign match   = valid_q && ent_q.id == key_id && ent_q.flags == key_flags;
	assign age     = ins_cnt - ent_q.order;
	// strict compare: an earlier cell keeps the candidate on a full tie
	assign better  = valid_q && (!found_in || ent_q.expiry < exp_in ||
		(ent_q.expiry == exp_in && age > age_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			found_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (ctl.load) begin
				valid_q <= 1'b1;
			end else if (ctl.clr || (ctl.purge && expired)) begin
				valid_q <= 1'b0;
			end
			found_q <= found_in || valid_q;
			cnt_q   <= cnt_in + CW'(valid_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			ent_q <= wdata;
		end
		if (better) begin
			exp_q <= ent_q.expiry;
			age_q <= age;
			idx_q <= IW'(SLOT);
		end else begin
			exp_q <= exp_in;
			age_q <= age_in;
			idx_q <= idx_in;
		end
	end

	assign valid     = valid_q;
	assign ent       = ent_q;
	assign found_out = found_q;
	assign exp_out   = exp_q;
	assign age_out   = age_q;
	assign idx_out   = idx_q;
	assign cnt_out   = cnt_q;

endmodule

// ===== hw/rtl/status_cache_with_expiry.sv =====
// Keyed status cache with time-to-live, one entry per (cert_id, key_flags).
// Input channel in_valid/in_ready carries one request transaction: mode 0 is
// a lookup, mode 1 stores new_status. now_time is the current time in seconds.
// Output channel out_valid/out_ready returns one transaction per request:
// result_status (0 unless a lookup hit a live entry) and entries_in_use.
// The write port (wr_en, wr_index, wr_data) sets max_entries, normal_ttl and
// wait_ttl; write it only while no request is in flight.
// Each entry sits in a cell of a row of CAPACITY+1 cells (one spare slot for
// an insert into a full table). A candidate for eviction and a live count
// ripple through the row, one cell per cycle. A request steps through the
// match, update and purge states, a scan of the row plus one more scan for
// each entry evicted, then the migrate and done states. One request is in
// work at a time.
// in_ready is high while idle, also when a finished result still waits: a
// receiver stall holds only the next result, which waits in its last state.
// Reset clears every entry, the insertion counter and the output valid flag,
// and returns the registers to max_entries 16, normal_ttl 3600, wait_ttl 60.
module status_cache_with_expiry import sce_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 mode,
	input  logic [ID_W-1:0]      cert_id,
	input  logic [FL_W-1:0]      key_flags,
	input  logic [ST_W-1:0]      new_status,
	input  logic [TM_W-1:0]      now_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ST_W-1:0]      result_status,
	output logic [CNT_OUT_W-1:0] entries_in_use
);

	localparam int SLOTS = CAPACITY + 1;
	localparam int IW    = $clog2(SLOTS);
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int LW    = (CW > MAXE_W) ? CW : MAXE_W;

	typedef enum logic [2:0] {
		S_IDLE, S_MATCH, S_UPDATE, S_PURGE, S_SCAN, S_MIGRATE, S_DONE
	} state_t;

	state_t             state_q;
	logic [MAXE_W-1:0]  max_entries_q;
	logic [TTL_W-1:0]   normal_ttl_q;
	logic [TTL_W-1:0]   wait_ttl_q;
	logic               mode_q;
	logic [ID_W-1:0]    id_q;
	logic [FL_W-1:0]    fl_q;
	logic [ST_W-1:0]    st_q;
	logic [TM_W-1:0]    now_q;
	logic [EXP_W-1:0]   exp_q;
	logic [SLOTS-1:0]   hit_q;
	logic [ORD_W-1:0]   ins_cnt_q;
	logic [CW-1:0]      scan_q;
	logic [ST_W-1:0]    result_q;
	logic [LW-1:0]      count_q;
	logic               out_valid_q;
	logic [ST_W-1:0]    out_status_q;
	logic [CNT_OUT_W-1:0] out_count_q;

	cell_ctl_t          ctl [SLOTS];
	entry_t             ent [SLOTS];
	logic [SLOTS-1:0]   match_v;
	logic [SLOTS-1:0]   valid_v;
	logic               ch_found [SLOTS+1];
	logic [EXP_W-1:0]   ch_exp   [SLOTS+1];
	logic [ORD_W-1:0]   ch_age   [SLOTS+1];
	logic [IW-1:0]      ch_idx   [SLOTS+1];
	logic [CW-1:0]      ch_cnt   [SLOTS+1];

	entry_t             hit_ent;
	entry_t             wdata;
	logic               hit_any;
	logic               drop;
	logic               insert;
	logic [SLOTS-1:0]   free_v;
	logic [SLOTS-1:0]   free_oh;
	logic [CAPACITY-1:0] mig_free;
	logic [CAPACITY-1:0] mig_oh;
	logic [LW-1:0]      limit;
	logic [LW-1:0]      tot_cnt;
	logic               scan_done;
	logic               over;

	// chain ends: nothing found and nothing counted before the first cell
	assign ch_found[0] = 1'b0;
	assign ch_exp[0]   = '0;
	assign ch_age[0]   = '0;
	assign ch_idx[0]   = '0;
	assign ch_cnt[0]   = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		sce_cell #(.IW(IW), .CW(CW), .SLOT(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[i]),
			.wdata     (wdata),
			.key_id    (id_q),
			.key_flags (fl_q),
			.now       (now_q),
			.ins_cnt   (ins_cnt_q),
			.found_in  (ch_found[i]),
			.exp_in    (ch_exp[i]),
			.age_in    (ch_age[i]),
			.idx_in    (ch_idx[i]),
			.cnt_in    (ch_cnt[i]),
			.match     (match_v[i]),
			.valid     (valid_v[i]),
			.ent       (ent[i]),
			.found_out (ch_found[i+1]),
			.exp_out   (ch_exp[i+1]),
			.age_out   (ch_age[i+1]),
			.idx_out   (ch_idx[i+1]),
			.cnt_out   (ch_cnt[i+1])
		);
	end

	// the matched entry; hit_q keeps only the lowest matching cell, one bit at most
	always_comb begin
		hit_ent = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (hit_q[i]) begin
				hit_ent = hit_ent | ent[i];
			end
		end
	end

	assign hit_any = |hit_q;
	// a lookup drops a stale hit or one whose status must be fetched afresh
	always_comb begin
		drop = 1'b0;
		if (mode_q == MODE_LOOKUP && hit_any) begin
			drop = hit_ent.expiry <= {1'b0, now_q} ||
				(hit_ent.status inside {ST_CONNECT, ST_ISSUER, ST_ERROR});
		end
	end
	assign insert  = !hit_any || drop;
	assign free_v  = ~valid_v | (drop ? hit_q : '0);
	assign free_oh = free_v & (~free_v + SLOTS'(1));

	// the spare slot moves down to the first free regular slot
	assign mig_free = ~valid_v[CAPACITY-1:0];
	assign mig_oh   = mig_free & (~mig_free + CAPACITY'(1));

	always_comb begin
		if (state_q == S_MIGRATE) begin
			wdata = ent[CAPACITY];
		end else begin
			wdata.id     = id_q;
			wdata.flags  = fl_q;
			wdata.status = (mode_q == MODE_STORE) ? st_q : ST_WAIT;
			wdata.expiry = exp_q;
			wdata.order  = insert ? ins_cnt_q : hit_ent.order;
		end
	end

	assign limit     = (LW'(max_entries_q) < LW'(CAPACITY)) ? LW'(max_entries_q)
		: LW'(CAPACITY);
	assign tot_cnt   = LW'(ch_cnt[SLOTS]);
	assign scan_done = state_q == S_SCAN && scan_q == CW'(SLOTS);
	assign over      = tot_cnt > limit;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			ctl[i] = '0;
			case (state_q)
				S_UPDATE: begin
					ctl[i].clr  = drop && hit_q[i];
					ctl[i].load = insert ? free_oh[i]
						: (mode_q == MODE_STORE && hit_q[i]);
				end
				S_PURGE: begin
					ctl[i].purge = 1'b1;
				end
				S_SCAN: begin
					ctl[i].clr = scan_done && over && ch_idx[SLOTS] == IW'(i);
				end
				S_MIGRATE: begin
					if (valid_v[CAPACITY]) begin
						if (i == CAPACITY) begin
							ctl[i].clr = 1'b1;
						end else begin
							ctl[i].load = mig_oh[i];
						end
					end
				end
				default: begin
					ctl[i] = '0;
				end
			endcase
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RST;
			normal_ttl_q  <= NORMAL_TTL_RST;
			wait_ttl_q    <= WAIT_TTL_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_MAX_ENTRIES: max_entries_q <= wr_data[MAXE_W-1:0];
				REG_NORMAL_TTL:  normal_ttl_q  <= wr_data[TTL_W-1:0];
				REG_WAIT_TTL:    wait_ttl_q    <= wr_data[TTL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// request sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ins_cnt_q   <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// raise valid with a fresh result, drop it once the receiver takes it
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (insert) begin
						ins_cnt_q <= ins_cnt_q + ORD_W'(1);
					end
					state_q <= S_PURGE;
				end
				S_PURGE: begin
					scan_q  <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// hold until the candidate has rippled through every cell
					if (scan_done) begin
						scan_q <= '0;
						if (!over) begin
							state_q <= S_MIGRATE;
						end
					end else begin
						scan_q <= scan_q + CW'(1);
					end
				end
				S_MIGRATE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			mode_q <= mode;
			id_q   <= cert_id;
			fl_q   <= key_flags;
			st_q   <= new_status;
			now_q  <= now_time;
		end
		if (state_q == S_MATCH) begin
			hit_q <= match_v & (~match_v + SLOTS'(1));
			exp_q <= {1'b0, now_q} + {1'b0,
				(mode_q == MODE_STORE) ? normal_ttl_q : wait_ttl_q};
		end
		if (state_q == S_UPDATE) begin
			result_q <= (mode_q == MODE_LOOKUP && hit_any && !drop) ? hit_ent.status
				: ST_NONE;
		end
		if (scan_done && !over) begin
			count_q <= tot_cnt;
		end
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_status_q <= result_q;
			out_count_q  <= count_q[CNT_OUT_W-1:0];
		end
	end

	assign in_ready       = state_q == S_IDLE;
	assign out_valid      = out_valid_q;
	assign result_status  = out_status_q;
	assign entries_in_use = out_count_q;

endmodule

// ===== hw/rtl/sce_chk.sv =====
module sce_chk import sce_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [ST_W-1:0]      result_status,
	input logic [CNT_OUT_W-1:0] entries_in_use
);

	// a request occupies the block: no second transaction right behind it
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a request is in work");

	a_busy_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> ##1 !in_ready)
		else $error("request finished too early");

	// a fresh result comes out together with the return to idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result shown while still busy");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(result_status) &&
		$stable(entries_in_use)))
		else $error("stalled result changed");

endmodule

bind status_cache_with_expiry sce_chk u_sce_chk (.*);
